@@ hdl/tps_pkg.sv @@
// Shared types for the track point simplifier: multiplier operand selects,
// output selects and the command/status bundles between controller and datapath.
// No dependencies.
`default_nettype none

package tps_pkg;

    typedef enum logic [3:0] {
        MUL_AX,   // a * point x
        MUL_BY,   // b * point y
        MUL_VV,   // v * v, v held in the accumulator
        MUL_TT,   // threshold * threshold
        MUL_AA,   // a * a
        MUL_BB,   // b * b
        MUL_ST,   // sum of squares (accumulator) * threshold squared
        MUL_D1,   // (prev x - tail x) * (point x - prev x)
        MUL_D2,   // (prev y - tail y) * (point y - prev y)
        MUL_LX,   // a * prev x, for a new line
        MUL_LY    // b * prev y, for a new line
    } mul_src_t;

    typedef enum logic [1:0] {
        OUT_NONE,
        OUT_IN,
        OUT_PREV,
        OUT_TAIL
    } out_sel_t;

    typedef struct packed {
        logic     latch;
        logic     start;
        mul_src_t src;
        logic     add;
        logic     add_c;
        logic     cap_lhs;
        logic     cap_t2;
        logic     set_ab;
        logic     set_c;
        logic     advance;
        logic     clear_seen;
        logic     out_load;
        out_sel_t out_sel;
        logic     out_acc;
        logic     out_last;
    } tps_cmd_t;

    typedef struct packed {
        logic       mul_done;
        logic       off_break;
        logic       acc_neg;
        logic       eq_prev;
        logic       tail_eq_prev;
        logic       opcode;
        logic [1:0] seen;
        logic       out_free;
    } tps_status_t;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_END  = 1'b1;

endpackage

`default_nettype wire

@@ hdl/tps_in_if.sv @@
// Input channel of the track point simplifier: valid/ready plus one point item.
// No dependencies.
`default_nettype none

interface tps_in_if #(
    parameter int COORD_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;

    modport source (output valid, opcode, point_x, point_y, input ready);
    modport sink   (input valid, opcode, point_x, point_y, output ready);
endinterface

`default_nettype wire

@@ hdl/tps_out_if.sv @@
// Result channel of the track point simplifier: valid/ready plus one result item.
// No dependencies.
`default_nettype none

interface tps_out_if #(
    parameter int COORD_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic                         is_point;
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic                         accepted;
    logic                         last;

    modport source (output valid, is_point, out_x, out_y, accepted, last, input ready);
    modport sink   (input valid, is_point, out_x, out_y, accepted, last, output ready);
endinterface

`default_nettype wire

@@ hdl/tps_ctrl.sv @@
// Controller of the track point simplifier: sequences multiplies, tests and emits.
// Depends on tps_pkg.
`default_nettype none

module tps_ctrl (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       in_valid,
    output logic                      in_ready,
    input  wire                       second_filter_mode,
    input  wire tps_pkg::tps_status_t st,
    output tps_pkg::tps_cmd_t         cmd
);
    import tps_pkg::*;

    typedef enum logic [23:0] {
        S_IDLE     = 24'h000001,
        S_DISPATCH = 24'h000002,
        S_MWAIT    = 24'h000004,
        S_V_BY     = 24'h000008,
        S_V_C      = 24'h000010,
        S_V_SQ     = 24'h000020,
        S_T_SQ     = 24'h000040,
        S_S_AA     = 24'h000080,
        S_S_BB     = 24'h000100,
        S_R_ST     = 24'h000200,
        S_CMP      = 24'h000400,
        S_D_2      = 24'h000800,
        S_D_CHK    = 24'h001000,
        S_EM_TAIL  = 24'h002000,
        S_EM_PREV  = 24'h004000,
        S_EM_ADV   = 24'h008000,
        S_EM_STAT0 = 24'h010000,
        S_EM_STAT1 = 24'h020000,
        S_EM_FIRST = 24'h040000,
        S_EM_END   = 24'h080000,
        S_LINE_AB  = 24'h100000,
        S_L_AX     = 24'h200000,
        S_L_BY     = 24'h400000,
        S_L_C      = 24'h800000
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cmd        = '0;
        cmd.src    = MUL_AX;
        cmd.out_sel = OUT_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (st.opcode == OP_END)
                    state_next = S_EM_END;
                else if (st.seen == 2'd0)
                    state_next = S_EM_FIRST;
                else if (st.seen == 2'd1)
                    state_next = st.eq_prev ? S_EM_STAT0 : S_EM_STAT1;
                else
                begin
                    cmd.start  = 1'b1;
                    cmd.src    = MUL_AX;
                    ret_next   = S_V_BY;
                    state_next = S_MWAIT;
                end
            end
            S_MWAIT:
            begin
                if (st.mul_done)
                    state_next = ret_reg;
            end
            S_V_BY:
            begin
                cmd.start  = 1'b1;
                cmd.src    = MUL_BY;
                cmd.add    = 1'b1;
                ret_next   = S_V_C;
                state_next = S_MWAIT;
            end
            S_V_C:
            begin
                cmd.add_c  = 1'b1;
                state_next = S_V_SQ;
            end
            S_V_SQ:
            begin
                cmd.start  = 1'b1;
                cmd.src    = MUL_VV;
                ret_next   = S_T_SQ;
                state_next = S_MWAIT;
            end
            S_T_SQ:
            begin
                cmd.cap_lhs = 1'b1;
                cmd.start   = 1'b1;
                cmd.src     = MUL_TT;
                ret_next    = S_S_AA;
                state_next  = S_MWAIT;
            end
            S_S_AA:
            begin
                cmd.cap_t2 = 1'b1;
                cmd.start  = 1'b1;
                cmd.src    = MUL_AA;
                ret_next   = S_S_BB;
                state_next = S_MWAIT;
            end
            S_S_BB:
            begin
                cmd.start  = 1'b1;
                cmd.src    = MUL_BB;
                cmd.add    = 1'b1;
                ret_next   = S_R_ST;
                state_next = S_MWAIT;
            end
            S_R_ST:
            begin
                cmd.start  = 1'b1;
                cmd.src    = MUL_ST;
                ret_next   = S_CMP;
                state_next = S_MWAIT;
            end
            S_CMP:
            begin
                if (st.off_break)
                    state_next = second_filter_mode ? S_EM_TAIL : S_EM_PREV;
                else if (st.tail_eq_prev)
                    state_next = S_EM_STAT0;
                else
                begin
                    cmd.start  = 1'b1;
                    cmd.src    = MUL_D1;
                    ret_next   = S_D_2;
                    state_next = S_MWAIT;
                end
            end
            S_D_2:
            begin
                cmd.start  = 1'b1;
                cmd.src    = MUL_D2;
                cmd.add    = 1'b1;
                ret_next   = S_D_CHK;
                state_next = S_MWAIT;
            end
            S_D_CHK:
            begin
                if (st.acc_neg)
                    state_next = second_filter_mode ? S_EM_TAIL : S_EM_PREV;
                else
                    state_next = S_EM_ADV;
            end
            S_EM_TAIL:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OUT_TAIL;
                    state_next   = S_EM_PREV;
                end
            end
            S_EM_PREV:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OUT_PREV;
                    cmd.out_acc  = !st.eq_prev;
                    cmd.out_last = 1'b1;
                    state_next   = st.eq_prev ? S_IDLE : S_LINE_AB;
                end
            end
            S_EM_ADV:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = 1'b1;
                    cmd.advance  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_EM_STAT0:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_EM_STAT1:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_acc  = 1'b1;
                    cmd.out_last = 1'b1;
                    state_next   = S_LINE_AB;
                end
            end
            S_EM_FIRST:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OUT_IN;
                    cmd.out_acc  = 1'b1;
                    cmd.out_last = 1'b1;
                    cmd.advance  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_EM_END:
            begin
                if (st.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_sel    = OUT_PREV;
                    cmd.out_last   = 1'b1;
                    cmd.clear_seen = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_LINE_AB:
            begin
                cmd.set_ab = 1'b1;
                state_next = S_L_AX;
            end
            S_L_AX:
            begin
                cmd.start  = 1'b1;
                cmd.src    = MUL_LX;
                ret_next   = S_L_BY;
                state_next = S_MWAIT;
            end
            S_L_BY:
            begin
                cmd.start  = 1'b1;
                cmd.src    = MUL_LY;
                cmd.add    = 1'b1;
                ret_next   = S_L_C;
                state_next = S_MWAIT;
            end
            S_L_C:
            begin
                cmd.set_c   = 1'b1;
                cmd.advance = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/tps_dp.sv @@
// Datapath of the track point simplifier: point and line state, shared
// 4-bit-per-cycle multiplier with accumulator, result register.
// Depends on tps_pkg.
`default_nettype none

module tps_dp #(
    parameter int COORD_BITS = 24
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire tps_pkg::tps_cmd_t       cmd,
    output tps_pkg::tps_status_t         st,
    input  wire [15:0]                   offset_threshold,
    input  wire                          in_opcode,
    input  wire signed [COORD_BITS-1:0]  in_x,
    input  wire signed [COORD_BITS-1:0]  in_y,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic                         out_is_point,
    output logic signed [COORD_BITS-1:0] out_x,
    output logic signed [COORD_BITS-1:0] out_y,
    output logic                         out_accepted,
    output logic                         out_last
);
    import tps_pkg::*;

    localparam int N    = COORD_BITS;
    localparam int AW   = N + 1;
    localparam int CW   = 2 * N + 2;
    localparam int OPW  = (2 * N + 4 > 32) ? 2 * N + 4 : 32;
    localparam int OW   = OPW + 1;
    localparam int PW   = 2 * OPW + 2;
    localparam int NIT  = (OPW + 3) / 4;
    localparam int CNTW = $clog2(NIT);

    logic               op_reg;
    logic signed [N-1:0] px_reg, py_reg;
    logic signed [N-1:0] prev_x_reg, prev_y_reg, tail_x_reg, tail_y_reg;
    logic signed [AW-1:0] a_reg, b_reg;
    logic signed [CW-1:0] c_reg;
    logic [1:0]          seen_reg;
    logic signed [PW-1:0] acc_reg, lhs_reg;
    logic signed [OW-1:0] t2_reg;

    logic [PW-1:0]       ma_reg, prod_reg;
    logic [OPW-1:0]      mb_reg;
    logic                neg_reg, add_reg, busy_reg, fin_reg;
    logic [CNTW-1:0]     cnt_reg;

    logic signed [OW-1:0] op_a, op_b, mag_a, mag_b;
    logic signed [AW-1:0] dx_pt, dy_pt, dx_pp, dy_pp;
    logic signed [PW-1:0] mul_res;

    // Input point and state registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg <= in_opcode;
            px_reg <= in_x;
            py_reg <= in_y;
        end
        if (cmd.cap_lhs)
            lhs_reg <= acc_reg;
        if (cmd.cap_t2)
            t2_reg <= acc_reg[OW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            tail_x_reg <= '0;
            tail_y_reg <= '0;
            a_reg      <= '0;
            b_reg      <= '0;
            c_reg      <= '0;
            seen_reg   <= '0;
        end
        else
        begin
            if (cmd.set_ab)
            begin
                a_reg <= AW'(py_reg) - AW'(prev_y_reg);
                b_reg <= AW'(prev_x_reg) - AW'(px_reg);
            end
            if (cmd.set_c)
                c_reg <= CW'(-acc_reg);
            if (cmd.advance)
            begin
                tail_x_reg <= prev_x_reg;
                tail_y_reg <= prev_y_reg;
                prev_x_reg <= px_reg;
                prev_y_reg <= py_reg;
                if (seen_reg != 2'd2)
                    seen_reg <= seen_reg + 2'd1;
            end
            if (cmd.clear_seen)
                seen_reg <= '0;
        end
    end

    // Operand selection
    assign dx_pp = AW'(prev_x_reg) - AW'(tail_x_reg);
    assign dy_pp = AW'(prev_y_reg) - AW'(tail_y_reg);
    assign dx_pt = AW'(px_reg) - AW'(prev_x_reg);
    assign dy_pt = AW'(py_reg) - AW'(prev_y_reg);

    always_comb
    begin
        case (cmd.src)
            MUL_AX:  begin op_a = OW'(a_reg); op_b = OW'(px_reg); end
            MUL_BY:  begin op_a = OW'(b_reg); op_b = OW'(py_reg); end
            MUL_VV:  begin op_a = acc_reg[OW-1:0]; op_b = acc_reg[OW-1:0]; end
            MUL_TT:
            begin
                op_a = OW'($signed({1'b0, offset_threshold}));
                op_b = OW'($signed({1'b0, offset_threshold}));
            end
            MUL_AA:  begin op_a = OW'(a_reg); op_b = OW'(a_reg); end
            MUL_BB:  begin op_a = OW'(b_reg); op_b = OW'(b_reg); end
            MUL_ST:  begin op_a = acc_reg[OW-1:0]; op_b = t2_reg; end
            MUL_D1:  begin op_a = OW'(dx_pp); op_b = OW'(dx_pt); end
            MUL_D2:  begin op_a = OW'(dy_pp); op_b = OW'(dy_pt); end
            MUL_LX:  begin op_a = OW'(a_reg); op_b = OW'(prev_x_reg); end
            MUL_LY:  begin op_a = OW'(b_reg); op_b = OW'(prev_y_reg); end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    assign mag_a   = op_a[OW-1] ? -op_a : op_a;
    assign mag_b   = op_b[OW-1] ? -op_b : op_b;
    assign mul_res = neg_reg ? -$signed(prod_reg) : $signed(prod_reg);

    // Shared multiplier: four multiplier bits per cycle, then fold into the accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            fin_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNTW'(1);
                if (cnt_reg == CNTW'(NIT - 1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            ma_reg   <= PW'(mag_a[OPW-1:0]);
            mb_reg   <= mag_b[OPW-1:0];
            neg_reg  <= op_a[OW-1] ^ op_b[OW-1];
            add_reg  <= cmd.add;
            prod_reg <= '0;
        end
        else if (busy_reg)
        begin
            prod_reg <= prod_reg + ma_reg * PW'(mb_reg[3:0]);
            ma_reg   <= ma_reg << 4;
            mb_reg   <= mb_reg >> 4;
        end
        if (fin_reg)
            acc_reg <= add_reg ? acc_reg + mul_res : mul_res;
        else if (cmd.add_c)
            acc_reg <= acc_reg + PW'(c_reg);
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (cmd.out_load)
            out_valid <= 1'b1;
        else if (out_ready)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_accepted <= cmd.out_acc;
            out_last     <= cmd.out_last;
            case (cmd.out_sel)
                OUT_IN:   begin out_is_point <= 1'b1; out_x <= px_reg; out_y <= py_reg; end
                OUT_PREV:
                begin
                    out_is_point <= 1'b1;
                    out_x        <= prev_x_reg;
                    out_y        <= prev_y_reg;
                end
                OUT_TAIL:
                begin
                    out_is_point <= 1'b1;
                    out_x        <= tail_x_reg;
                    out_y        <= tail_y_reg;
                end
                default:  begin out_is_point <= 1'b0; out_x <= '0; out_y <= '0; end
            endcase
        end
    end

    assign st.mul_done     = fin_reg;
    assign st.off_break    = lhs_reg > acc_reg;
    assign st.acc_neg      = acc_reg[PW-1];
    assign st.eq_prev      = (px_reg == prev_x_reg) && (py_reg == prev_y_reg);
    assign st.tail_eq_prev = (tail_x_reg == prev_x_reg) && (tail_y_reg == prev_y_reg);
    assign st.opcode       = op_reg;
    assign st.seen         = seen_reg;
    assign st.out_free     = !out_valid || out_ready;

endmodule

`default_nettype wire

@@ hdl/track_point_simplifier.sv @@
// Track point simplifier top level: APB configuration registers, controller, datapath.
// An end item or a first or second point gets its result without a multiply; a later
// point takes 7 to 11 multiplies on the single shared 4-bit-per-cycle multiplier,
// which works through OPW = max(2*COORD_BITS+4, 32) operand bits (52 at the default)
// per multiply. One item is in work at a time.
// Reset (rst_n, asynchronous, active low) clears points, line, count and registers.
// Depends on tps_pkg, tps_in_if, tps_out_if, tps_ctrl, tps_dp.
`default_nettype none

module track_point_simplifier #(
    parameter int COORD_BITS = 24
) (
    input  wire          clk,
    input  wire          rst_n,
    tps_in_if.sink       in_ch,
    tps_out_if.source    out_ch,
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire [2:0]    paddr,
    input  wire [31:0]   pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import tps_pkg::*;

    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_MODE      = 1'b1;

    logic [15:0] offset_threshold_reg;
    logic        second_filter_mode_reg;
    logic        cfg_write;

    tps_cmd_t    cmd;
    tps_status_t st;

    // Configuration: a transfer writes in its access phase; word index is paddr[2]
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_threshold_reg   <= '0;
            second_filter_mode_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_THRESHOLD: offset_threshold_reg   <= pwdata[15:0];
                REG_MODE:      second_filter_mode_reg <= pwdata[0];
                default:       offset_threshold_reg   <= offset_threshold_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_THRESHOLD: prdata = {16'd0, offset_threshold_reg};
            REG_MODE:      prdata = {31'd0, second_filter_mode_reg};
            default:       prdata = '0;
        endcase
    end

    // Controller: takes one input transfer when idle, then sequences the datapath
    tps_ctrl u_ctrl (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_ch.valid),
        .in_ready           (in_ch.ready),
        .second_filter_mode (second_filter_mode_reg),
        .st                 (st),
        .cmd                (cmd)
    );

    // Datapath: holds the track state and the result register, which parts
    // the output side so a new item can be taken while the last result waits
    tps_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .st               (st),
        .offset_threshold (offset_threshold_reg),
        .in_opcode        (in_ch.opcode),
        .in_x             (in_ch.point_x),
        .in_y             (in_ch.point_y),
        .out_valid        (out_ch.valid),
        .out_ready        (out_ch.ready),
        .out_is_point     (out_ch.is_point),
        .out_x            (out_ch.out_x),
        .out_y            (out_ch.out_y),
        .out_accepted     (out_ch.accepted),
        .out_last         (out_ch.last)
    );

endmodule

`default_nettype wire

@@ bench/tps_tb_pkg.sv @@
// Predictor types for the track point simplifier bench: one expected result item.
// Depends on nothing.
`default_nettype none

package tps_tb_pkg;

    typedef struct {
        logic            is_point;
        logic [23:0]     x;
        logic [23:0]     y;
        logic            accepted;
        logic            last;
    } tps_result_t;

endpackage

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking bench for track_point_simplifier: drives points and end items over the
// input channel, predicts results with an exact integer model, checks every transfer.
// Depends on tps_pkg, tps_tb_pkg, tps_in_if, tps_out_if and the RTL.
`default_nettype none

module testbench;
    import tps_pkg::*;
    import tps_tb_pkg::*;

    localparam int REG_THRESHOLD = 0;
    localparam int REG_SECOND    = 1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    tps_in_if  #(.COORD_BITS(24)) in_ch ();
    tps_out_if #(.COORD_BITS(24)) out_ch ();

    track_point_simplifier #(.COORD_BITS(24)) u_top (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #2 clk = ~clk;

    // Predictor state: mirror of the block's points, line, count and registers
    logic signed [23:0]  prev_x, prev_y, tail_x, tail_y;
    logic signed [24:0]  line_a, line_b;
    logic signed [49:0]  line_c;
    int unsigned         seen;
    logic [15:0]         thresh;
    logic                second_mode;

    tps_result_t expected_q[$];
    int errors = 0;
    int results_seen = 0;
    int points_sent = 0;
    bit quiet = 1'b0;     // no idling on either side when set

    task automatic report(input string what);
        errors++;
        $display("mismatch: %s", what);
    endtask

    task automatic push_result(input logic isp, input logic [23:0] x, input logic [23:0] y,
                               input logic acc, input logic lst);
        tps_result_t r;
        r.is_point = isp; r.x = x; r.y = y; r.accepted = acc; r.last = lst;
        expected_q.push_back(r);
    endtask

    task automatic set_line_through(input logic signed [23:0] x0, input logic signed [23:0] y0,
                                    input logic signed [23:0] x1, input logic signed [23:0] y1);
        line_a = 25'(y1) - 25'(y0);
        line_b = 25'(x0) - 25'(x1);
        line_c = -(50'(line_a) * 50'(x0) + 50'(line_b) * 50'(y0));
    endtask

    task automatic take_point(input logic signed [23:0] x, input logic signed [23:0] y);
        tail_x = prev_x; tail_y = prev_y;
        prev_x = x; prev_y = y;
        if (seen < 2) seen++;
    endtask

    // Work out the results of one item and update the predictor state
    task automatic predict_simplify(input logic op, input logic signed [23:0] x,
                                    input logic signed [23:0] y);
        logic signed [75:0]  offset_v;
        logic        [151:0] lhs, rhs;
        logic signed [51:0]  dot;
        logic brk, ok;
        if (op == OP_END) begin
            push_result(1'b1, prev_x, prev_y, 1'b0, 1'b1);
            seen = 0;
            return;
        end
        if (seen == 0) begin
            push_result(1'b1, x, y, 1'b1, 1'b1);
            take_point(x, y);
            return;
        end
        if (seen == 1) begin
            if (x == prev_x && y == prev_y) begin
                push_result(1'b0, '0, '0, 1'b0, 1'b1);
                return;
            end
            set_line_through(prev_x, prev_y, x, y);
            take_point(x, y);
            push_result(1'b0, '0, '0, 1'b1, 1'b1);
            return;
        end
        offset_v = 76'(line_a) * 76'(x) + 76'(line_b) * 76'(y) + 76'(line_c);
        if (offset_v < 0) offset_v = -offset_v;
        lhs = 152'(offset_v) * 152'(offset_v);
        rhs = (152'(thresh) * 152'(thresh)) *
              (152'(51'(line_a) * 51'(line_a)) + 152'(51'(line_b) * 51'(line_b)));
        brk = lhs > rhs;
        if (!brk) begin
            if (tail_x == prev_x && tail_y == prev_y) begin
                push_result(1'b0, '0, '0, 1'b0, 1'b1);
                return;
            end
            dot = (52'(prev_x) - 52'(tail_x)) * (52'(x) - 52'(prev_x)) +
                  (52'(prev_y) - 52'(tail_y)) * (52'(y) - 52'(prev_y));
            brk = dot < 0;
        end
        if (!brk) begin
            take_point(x, y);
            push_result(1'b0, '0, '0, 1'b0, 1'b1);
            return;
        end
        ok = !(x == prev_x && y == prev_y);
        if (second_mode) push_result(1'b1, tail_x, tail_y, 1'b0, 1'b0);
        push_result(1'b1, prev_x, prev_y, ok, 1'b1);
        if (ok) begin
            set_line_through(prev_x, prev_y, x, y);
            take_point(x, y);
        end
    endtask

    // Send one item; the predictor runs at the transfer. Valid stays high after the
    // transfer until the next item, an idle burst or a drain drops it.
    task automatic send_item(input logic op, input logic signed [23:0] x,
                             input logic signed [23:0] y);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.opcode  <= op;
        in_ch.point_x <= x;
        in_ch.point_y <= y;
        do @(posedge clk); while (!in_ch.ready);
        predict_simplify(op, x, y);
        points_sent++;
    endtask

    // Result side: random stall bursts, compare each transfer with the oldest expectation
    initial begin
        tps_result_t e;
        int stall;
        stall = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (expected_q.size() == 0) report("result with nothing expected");
                else begin
                    e = expected_q.pop_front();
                    if (out_ch.is_point !== e.is_point) report("is_point");
                    if (out_ch.out_x !== e.x)
                        report($sformatf("out_x %h, want %h", out_ch.out_x, e.x));
                    if (out_ch.out_y !== e.y)
                        report($sformatf("out_y %h, want %h", out_ch.out_y, e.y));
                    if (out_ch.accepted !== e.accepted) report("accepted");
                    if (out_ch.last !== e.last) report("last");
                end
            end
            if (stall > 0) stall--;
            else if (!quiet && $urandom_range(0, 4) == 0) stall = $urandom_range(1, 3);
            out_ch.ready <= (stall == 0);
        end
    end

    // One write; the select stays up so a following write goes straight to its setup phase
    task automatic apb_write(input int idx, input logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 3'(4 * idx); pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (idx == REG_THRESHOLD) thresh = val[15:0];
        else second_mode = val[0];
    endtask

    // Drop valid, hold until every expected result has come, then let the block settle
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic configure(input logic [15:0] t, input logic mode);
        drain_results();
        apb_write(REG_THRESHOLD, 32'(t));
        apb_write(REG_SECOND, 32'(mode));
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    function automatic logic signed [23:0] rand_coord(input int span);
        int r;
        if (span <= 0) return 24'($urandom);
        r = $urandom_range(0, 2 * span);
        return 24'(r - span);
    endfunction

    // Directed: extremes, first/second point cases, rejections, breaks, end items
    task automatic test_directed();
        configure(16'd0, 1'b0);
        send_item(OP_END, 24'sd5, -24'sd5);            // end straight after reset
        send_item(OP_PUSH, 24'h800000, 24'h7FFFFF);
        send_item(OP_PUSH, 24'h800000, 24'h7FFFFF);    // second equals first
        send_item(OP_PUSH, 24'h7FFFFF, 24'h800000);
        send_item(OP_PUSH, 24'h800000, 24'h7FFFFF);    // far turn back
        send_item(OP_PUSH, 24'h800000, 24'h7FFFFF);    // equal point, no break
        send_item(OP_END, 24'sd0, 24'sd0);
        configure(16'hFFFF, 1'b1);
        send_item(OP_PUSH, 24'sd0, 24'sd0);
        send_item(OP_PUSH, 24'sd10, 24'sd0);
        send_item(OP_PUSH, 24'sd20, 24'sd3);            // within threshold
        send_item(OP_PUSH, 24'sd5, 24'sd3);             // turns back
        send_item(OP_PUSH, 24'sd5, 24'sd3);             // no break; tail now equals previous
        send_item(OP_PUSH, -24'sd100, 24'sd3);
        send_item(OP_END, 24'sd0, 24'sd0);
        configure(16'd1, 1'b1);
        send_item(OP_PUSH, 24'sd0, 24'sd0);
        send_item(OP_PUSH, 24'sd4, 24'sd4);
        send_item(OP_PUSH, 24'sd8, 24'sd8);
        send_item(OP_PUSH, 24'sd12, 24'sd20);           // offset break
        send_item(OP_PUSH, 24'sd12, 24'sd20);           // tail equals previous now
        send_item(OP_PUSH, 24'h7FFFFF, 24'h7FFFFF);
        send_item(OP_END, 24'sd0, 24'sd0);
    endtask

    // Random tracks: mostly wandering walks with mixed step sizes, some noise
    task automatic test_random_tracks(input int n_items);
        logic signed [23:0] x, y;
        int span, len;
        x = 0; y = 0;
        while (n_items > 0) begin
            if ($urandom_range(0, 9) == 0)
                configure(16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 40)),
                          1'($urandom));
            len = $urandom_range(1, 14);
            span = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 60);
            x = rand_coord(span == 0 ? 0 : 100000);
            y = rand_coord(span == 0 ? 0 : 100000);
            repeat (len) begin
                if (span == 0) begin
                    x = 24'($urandom); y = 24'($urandom);
                end else if ($urandom_range(0, 7) != 0) begin
                    x = x + rand_coord(span); y = y + rand_coord(span);
                end
                send_item(OP_PUSH, x, y);
                n_items--;
            end
            send_item(OP_END, 24'($urandom), 24'($urandom));
            n_items--;
            if ($urandom_range(0, 15) == 0) drain_results();   // sender pauses for all
        end
    endtask

    initial begin
        in_ch.valid <= 1'b0;
        in_ch.opcode <= OP_PUSH;
        in_ch.point_x <= '0;
        in_ch.point_y <= '0;
        prev_x = 0; prev_y = 0; tail_x = 0; tail_y = 0;
        line_a = 0; line_b = 0; line_c = 0; seen = 0;
        thresh = 0; second_mode = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_tracks(280);
        quiet = 1'b1;
        test_random_tracks(80);
        drain_results();
        $display("covered %0d items, %0d results, thresholds and both filter modes",
                 points_sent, results_seen);
        if (errors == 0)
            $display("[track_point_simplifier] OK");
        else
            $display("[track_point_simplifier] ERROR");
        $finish;
    end

    initial begin
        #2000000;
        $display("[track_point_simplifier] ERROR");
        $finish;
    end
endmodule

`default_nettype wire
